>>> hdl/owvq_pkg.sv
`timescale 1ns / 1ps
// Shared constants and types for the orientation window vote quantizer.
package owvq_pkg;

    localparam int MAX_WIDTH_DEF   = 1024;
    localparam int HALF_WINDOW_DEF = 1;

    localparam int NUM_BINS  = 16;
    localparam int BIN_W     = 4;
    localparam int CODE_W    = 5;
    localparam int ROW_W     = 16;
    localparam int COL_W     = 11;
    localparam int OUT_COL_W = 10;
    localparam int STR_W     = 15;
    localparam int DIR_W     = 13;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 16;
    localparam int Q_DEPTH   = 4;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH        = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STRENGTH_THRESHOLD = 2'd2;

    localparam logic [COL_W-1:0] WIDTH_RST     = 11'd640;
    localparam logic [ROW_W-1:0] HEIGHT_RST    = 16'd480;
    localparam logic [STR_W-1:0] THRESHOLD_RST = 15'd51;

    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic             last_row;
        logic             last_col;
    } job_meta_t;

    typedef struct packed {
        logic [ROW_W-1:0]     row;
        logic [OUT_COL_W-1:0] col;
        logic                 run_last;
        logic                 frame_last;
    } res_meta_t;

endpackage

>>> hdl/owvq_front.sv
`timescale 1ns / 1ps
// Front end: config registers, pixel position, code classing, line memories and window.
module owvq_front import owvq_pkg::*; #(
    parameter int MAX_WIDTH   = MAX_WIDTH_DEF,
    parameter int HALF_WINDOW = HALF_WINDOW_DEF,
    localparam int SPAN   = 2 * HALF_WINDOW + 1,
    localparam int NCELL  = SPAN * SPAN,
    localparam int OFF_W  = $clog2(HALF_WINDOW + 1),
    localparam int JOB_W  = NCELL * CODE_W + 2 * SPAN + 2 * OFF_W + $bits(job_meta_t),
    localparam int QCNT_W = $clog2(Q_DEPTH + 1)
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [STR_W-1:0]     s_strength,
    input  logic [DIR_W-1:0]     s_direction,
    input  logic [QCNT_W-1:0]    q_count,
    output logic                 job_push,
    output logic [JOB_W-1:0]     job_data
);

    localparam int SLOT_W    = $clog2(SPAN);
    localparam int W_CAP     = (MAX_WIDTH < 2047) ? MAX_WIDTH : 2047;
    localparam int ADDR_W    = $clog2(W_CAP);
    localparam int BIN_STEP  = 180;
    localparam int HALF_TURN = 2880;

    function automatic logic [BIN_W-1:0] bin_of(input logic [DIR_W-1:0] dir);
        logic [DIR_W-1:0] a;
        logic [BIN_W-1:0] b;
        a = (dir > DIR_W'(HALF_TURN)) ? dir - DIR_W'(HALF_TURN) : dir;
        b = '0;
        for (int k = 1; k < NUM_BINS; k++) begin
            if (a > DIR_W'(k * BIN_STEP)) b = BIN_W'(k);
        end
        if (a > DIR_W'(HALF_TURN)) b = '0;
        return b;
    endfunction

    function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s);
        return (s == SLOT_W'(SPAN - 1)) ? '0 : s + SLOT_W'(1);
    endfunction

    logic [COL_W-1:0]  width_reg;
    logic [ROW_W-1:0]  height_reg;
    logic [STR_W-1:0]  thr_reg;
    logic [ROW_W-1:0]  in_row_reg, nxt_row;
    logic [COL_W-1:0]  in_col_reg, nxt_col;
    logic [SLOT_W-1:0] in_slot_reg, nxt_slot;

    logic [COL_W-1:0]  w_eff;
    logic [ROW_W-1:0]  h_eff;
    logic              col_wrap;
    logic [ROW_W:0]    row_step, row_up;
    logic [COL_W:0]    col_up;
    logic [SLOT_W-1:0] slot_step, cur_slot;
    logic [ROW_W-1:0]  cur_row;
    logic [COL_W-1:0]  cur_col;
    logic              accept;
    logic [CODE_W-1:0] code;
    logic [SPAN-1:0]   row_ok, col_ok;
    logic              row_deep, col_deep;
    logic [OFF_W-1:0]  dr_lo, dc_lo;
    logic              has_out;
    job_meta_t         meta;

    logic              s1_valid_reg;
    logic [CODE_W-1:0] s1_code_reg;
    logic [SLOT_W-1:0] s1_slot_reg;
    logic [SPAN-1:0]   s1_rowok_reg, s1_colok_reg;
    logic [OFF_W-1:0]  s1_drlo_reg, s1_dclo_reg;
    logic              s1_has_out_reg;
    job_meta_t         s1_meta_reg;
    logic [CODE_W-1:0] rd_reg [SPAN];

    logic [NCELL*CODE_W-1:0] win_reg, win_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= WIDTH_RST;
            height_reg <= HEIGHT_RST;
            thr_reg    <= THRESHOLD_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_FRAME_WIDTH:        width_reg  <= cfg_data[COL_W-1:0];
                REG_FRAME_HEIGHT:       height_reg <= cfg_data[ROW_W-1:0];
                REG_STRENGTH_THRESHOLD: thr_reg    <= cfg_data[STR_W-1:0];
                default: ;
            endcase
        end
    end

    assign s_ready = ({1'b0, q_count} + {{QCNT_W{1'b0}}, s1_valid_reg})
                     < (QCNT_W + 1)'(Q_DEPTH);
    assign accept  = s_valid && s_ready;

    always_comb begin
        w_eff = (width_reg > COL_W'(W_CAP)) ? COL_W'(W_CAP)
              : ((width_reg == '0) ? COL_W'(1) : width_reg);
        h_eff = (height_reg == '0) ? ROW_W'(1) : height_reg;

        // Wrap a position left stale by a register write.
        col_wrap  = in_col_reg >= w_eff;
        row_step  = {1'b0, in_row_reg} + {{ROW_W{1'b0}}, col_wrap};
        slot_step = col_wrap ? slot_inc(in_slot_reg) : in_slot_reg;
        if (row_step >= {1'b0, h_eff}) begin
            cur_row  = '0;
            cur_slot = '0;
        end else begin
            cur_row  = row_step[ROW_W-1:0];
            cur_slot = slot_step;
        end
        cur_col = col_wrap ? '0 : in_col_reg;

        // Advance to the next pixel.
        col_up = {1'b0, cur_col} + (COL_W + 1)'(1);
        row_up = {1'b0, cur_row} + (ROW_W + 1)'(1);
        if (col_up >= {1'b0, w_eff}) begin
            nxt_col = '0;
            if (row_up >= {1'b0, h_eff}) begin
                nxt_row  = '0;
                nxt_slot = '0;
            end else begin
                nxt_row  = row_up[ROW_W-1:0];
                nxt_slot = slot_inc(cur_slot);
            end
        end else begin
            nxt_col  = col_up[COL_W-1:0];
            nxt_row  = cur_row;
            nxt_slot = cur_slot;
        end

        code = {s_strength > thr_reg, bin_of(s_direction)};

        for (int i = 0; i < SPAN; i++) begin
            row_ok[i] = cur_row >= ROW_W'(2 * HALF_WINDOW - i);
            col_ok[i] = cur_col >= COL_W'(2 * HALF_WINDOW - i);
        end
        row_deep = cur_row >= ROW_W'(HALF_WINDOW);
        col_deep = cur_col >= COL_W'(HALF_WINDOW);
        dr_lo = row_deep ? '0 : OFF_W'(HALF_WINDOW) - cur_row[OFF_W-1:0];
        dc_lo = col_deep ? '0 : OFF_W'(HALF_WINDOW) - cur_col[OFF_W-1:0];
        meta.row      = cur_row;
        meta.col      = cur_col;
        meta.last_row = cur_row == h_eff - ROW_W'(1);
        meta.last_col = cur_col == w_eff - COL_W'(1);
        has_out = (meta.last_row || row_deep) && (meta.last_col || col_deep);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_row_reg   <= '0;
            in_col_reg   <= '0;
            in_slot_reg  <= '0;
            s1_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= accept;
            if (accept) begin
                in_row_reg  <= nxt_row;
                in_col_reg  <= nxt_col;
                in_slot_reg <= nxt_slot;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_code_reg    <= code;
            s1_slot_reg    <= cur_slot;
            s1_rowok_reg   <= row_ok;
            s1_colok_reg   <= col_ok;
            s1_drlo_reg    <= dr_lo;
            s1_dclo_reg    <= dc_lo;
            s1_has_out_reg <= has_out;
            s1_meta_reg    <= meta;
        end
    end

    // One line memory per row slot; all are read at the current column.
    for (genvar m = 0; m < SPAN; m++) begin : g_line
        logic [CODE_W-1:0] line_mem [W_CAP];
        always_ff @(posedge aclk) begin
            if (accept && cur_slot == SLOT_W'(m)) line_mem[cur_col[ADDR_W-1:0]] <= code;
            if (accept) rd_reg[m] <= line_mem[cur_col[ADDR_W-1:0]];
        end
    end

    always_comb begin
        win_next = win_reg;
        for (int i = 0; i < SPAN; i++) begin
            for (int j = 0; j < SPAN - 1; j++) begin
                win_next[(i*SPAN+j)*CODE_W +: CODE_W] = win_reg[(i*SPAN+j+1)*CODE_W +: CODE_W];
            end
        end
        // Oldest window row maps to the slot just after the current one.
        for (int i = 0; i < SPAN - 1; i++) begin
            for (int k = 0; k < SPAN; k++) begin
                if (s1_slot_reg == SLOT_W'(k)) begin
                    win_next[(i*SPAN+SPAN-1)*CODE_W +: CODE_W] = rd_reg[(k + i + 1) % SPAN];
                end
            end
        end
        win_next[(NCELL-1)*CODE_W +: CODE_W] = s1_code_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_reg <= '0;
        end else if (s1_valid_reg) begin
            win_reg <= win_next;
        end
    end

    assign job_push = s1_valid_reg && s1_has_out_reg;
    assign job_data = {win_next, s1_rowok_reg, s1_colok_reg, s1_drlo_reg, s1_dclo_reg,
                       s1_meta_reg};

endmodule

>>> hdl/owvq_job_fifo.sv
`timescale 1ns / 1ps
// Short job queue between the front end and the vote back end.
module owvq_job_fifo import owvq_pkg::*; #(
    parameter int WIDTH = 8,
    localparam int QCNT_W = $clog2(Q_DEPTH + 1)
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  logic [WIDTH-1:0]  push_data,
    input  logic              pop,
    output logic              head_valid,
    output logic [WIDTH-1:0]  head_data,
    output logic [QCNT_W-1:0] count
);

    localparam int PTR_W = $clog2(Q_DEPTH);

    logic [WIDTH-1:0]  slot_reg [Q_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic              do_push, do_pop;

    assign head_valid = count_reg != '0;
    assign head_data  = slot_reg[rd_ptr_reg];
    assign count      = count_reg;
    assign do_push    = push && (count_reg < QCNT_W'(Q_DEPTH));
    assign do_pop     = pop && head_valid;

    always_ff @(posedge aclk) begin
        if (do_push) slot_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) wr_ptr_reg <= (wr_ptr_reg == PTR_W'(Q_DEPTH - 1)) ? '0
                                       : wr_ptr_reg + PTR_W'(1);
            if (do_pop)  rd_ptr_reg <= (rd_ptr_reg == PTR_W'(Q_DEPTH - 1)) ? '0
                                       : rd_ptr_reg + PTR_W'(1);
            count_reg <= count_reg + QCNT_W'(do_push) - QCNT_W'(do_pop);
        end
    end

endmodule

>>> hdl/owvq_expand.sv
`timescale 1ns / 1ps
// Expands one window job into its result requests, one per cycle while adv is high, in raster order.
module owvq_expand import owvq_pkg::*; #(
    parameter int HALF_WINDOW = HALF_WINDOW_DEF,
    localparam int SPAN  = 2 * HALF_WINDOW + 1,
    localparam int NCELL = SPAN * SPAN,
    localparam int OFF_W = $clog2(HALF_WINDOW + 1),
    localparam int JOB_W = NCELL * CODE_W + 2 * SPAN + 2 * OFF_W + $bits(job_meta_t)
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   head_valid,
    input  logic [JOB_W-1:0]       head_data,
    output logic                   pop,
    input  logic                   adv,
    output logic                   res_valid,
    output logic [NCELL*BIN_W-1:0] res_bins,
    output logic [NCELL-1:0]       res_ok,
    output res_meta_t              res_meta
);

    localparam int META_W = $bits(job_meta_t);

    job_meta_t               meta;
    logic [OFF_W-1:0]        dr_lo, dc_lo, dr_hi, dc_hi, cur_dr, cur_dc;
    logic [SPAN-1:0]         row_ok, col_ok;
    logic [NCELL*CODE_W-1:0] snap;
    logic                    active_reg;
    logic [OFF_W-1:0]        dr_reg, dc_reg;
    logic                    take, end_col, end_row;
    logic [COL_W-1:0]        col_full;

    assign meta   = head_data[META_W-1:0];
    assign dc_lo  = head_data[META_W +: OFF_W];
    assign dr_lo  = head_data[META_W+OFF_W +: OFF_W];
    assign col_ok = head_data[META_W+2*OFF_W +: SPAN];
    assign row_ok = head_data[META_W+2*OFF_W+SPAN +: SPAN];
    assign snap   = head_data[META_W+2*OFF_W+2*SPAN +: NCELL*CODE_W];

    assign dr_hi  = meta.last_row ? OFF_W'(HALF_WINDOW) : '0;
    assign dc_hi  = meta.last_col ? OFF_W'(HALF_WINDOW) : '0;
    assign cur_dr = active_reg ? dr_reg : dr_lo;
    assign cur_dc = active_reg ? dc_reg : dc_lo;

    assign end_col   = cur_dc == dc_hi;
    assign end_row   = cur_dr == dr_hi;
    assign take      = head_valid && adv;
    assign pop       = take && end_col && end_row;
    assign res_valid = head_valid;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= 1'b0;
        end else if (take) begin
            active_reg <= !(end_col && end_row);
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            if (end_col) begin
                dr_reg <= cur_dr + OFF_W'(1);
                dc_reg <= dc_lo;
            end else begin
                dr_reg <= cur_dr;
                dc_reg <= cur_dc + OFF_W'(1);
            end
        end
    end

    // Pick the result's own window out of the snapshot; drop cells outside the frame.
    always_comb begin
        res_bins = '0;
        res_ok   = '0;
        for (int a = 0; a < SPAN; a++) begin
            for (int b = 0; b < SPAN; b++) begin
                for (int d = 0; d <= HALF_WINDOW; d++) begin
                    for (int e = 0; e <= HALF_WINDOW; e++) begin
                        if (a + d < SPAN && b + e < SPAN &&
                            cur_dr == OFF_W'(d) && cur_dc == OFF_W'(e)) begin
                            res_bins[(a*SPAN+b)*BIN_W +: BIN_W] =
                                snap[((a+d)*SPAN+b+e)*CODE_W +: BIN_W];
                            res_ok[a*SPAN+b] = snap[((a+d)*SPAN+b+e)*CODE_W + BIN_W]
                                               & row_ok[a+d] & col_ok[b+e];
                        end
                    end
                end
            end
        end
    end

    assign col_full = meta.col - COL_W'(HALF_WINDOW) + COL_W'(cur_dc);

    always_comb begin
        res_meta.row        = meta.row - ROW_W'(HALF_WINDOW) + ROW_W'(cur_dr);
        res_meta.col        = col_full[OUT_COL_W-1:0];
        res_meta.run_last   = end_col && end_row;
        res_meta.frame_last = meta.last_row && meta.last_col &&
                              cur_dr == OFF_W'(HALF_WINDOW) && cur_dc == OFF_W'(HALF_WINDOW);
    end

endmodule

>>> hdl/owvq_vote.sv
`timescale 1ns / 1ps
// Vote pipeline: one window cell per stage, then the one-hot output register.
module owvq_vote import owvq_pkg::*; #(
    parameter int HALF_WINDOW = HALF_WINDOW_DEF,
    localparam int SPAN  = 2 * HALF_WINDOW + 1,
    localparam int NCELL = SPAN * SPAN
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   in_valid,
    input  logic [NCELL*BIN_W-1:0] in_bins,
    input  logic [NCELL-1:0]       in_ok,
    input  res_meta_t              in_meta,
    output logic                   adv,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [ROW_W-1:0]       m_pixel_row,
    output logic [OUT_COL_W-1:0]   m_pixel_col,
    output logic [NUM_BINS-1:0]    m_bin_onehot,
    output logic                   m_run_last,
    output logic                   m_frame_last
);

    localparam int CNT_W  = $clog2(NCELL + 1);
    localparam int CENTER = HALF_WINDOW * SPAN + HALF_WINDOW;

    logic                   st_valid_reg [NCELL];
    logic [CNT_W-1:0]       st_cnt_reg   [NCELL][NUM_BINS];
    logic [CNT_W-1:0]       st_best_reg  [NCELL];
    logic [BIN_W-1:0]       st_win_reg   [NCELL];
    logic [NCELL*BIN_W-1:0] st_bins_reg  [NCELL];
    logic [NCELL-1:0]       st_ok_reg    [NCELL];
    res_meta_t              st_meta_reg  [NCELL];

    logic                   m_valid_reg;
    logic [ROW_W-1:0]       m_row_reg;
    logic [OUT_COL_W-1:0]   m_col_reg;
    logic [NUM_BINS-1:0]    m_onehot_reg;
    logic                   m_run_reg, m_frame_reg;

    assign adv = !m_valid_reg || m_ready;

    for (genvar k = 0; k < NCELL; k++) begin : g_stage
        logic                   pv_valid;
        logic [CNT_W-1:0]       pv_cnt [NUM_BINS];
        logic [CNT_W-1:0]       pv_best;
        logic [BIN_W-1:0]       pv_win;
        logic [NCELL*BIN_W-1:0] pv_bins;
        logic [NCELL-1:0]       pv_ok;
        res_meta_t              pv_meta;
        logic [CNT_W-1:0]       nx_cnt [NUM_BINS];
        logic [CNT_W-1:0]       nx_best, hit;
        logic [BIN_W-1:0]       nx_win, b;

        if (k == 0) begin : g_first
            always_comb begin
                pv_valid = in_valid;
                for (int n = 0; n < NUM_BINS; n++) pv_cnt[n] = '0;
                pv_best = '0;
                pv_win  = '0;
                pv_bins = in_bins;
                pv_ok   = in_ok;
                pv_meta = in_meta;
            end
        end else begin : g_next
            always_comb begin
                pv_valid = st_valid_reg[k-1];
                for (int n = 0; n < NUM_BINS; n++) pv_cnt[n] = st_cnt_reg[k-1][n];
                pv_best = st_best_reg[k-1];
                pv_win  = st_win_reg[k-1];
                pv_bins = st_bins_reg[k-1];
                pv_ok   = st_ok_reg[k-1];
                pv_meta = st_meta_reg[k-1];
            end
        end

        // Count this cell; a bin wins only by passing the best count so far.
        always_comb begin
            b       = pv_bins[k*BIN_W +: BIN_W];
            hit     = pv_cnt[b] + CNT_W'(1);
            nx_cnt  = pv_cnt;
            nx_best = pv_best;
            nx_win  = pv_win;
            if (pv_ok[k]) begin
                nx_cnt[b] = hit;
                if (hit > pv_best) begin
                    nx_best = hit;
                    nx_win  = b;
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                st_valid_reg[k] <= 1'b0;
            end else if (adv) begin
                st_valid_reg[k] <= pv_valid;
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                for (int n = 0; n < NUM_BINS; n++) st_cnt_reg[k][n] <= nx_cnt[n];
                st_best_reg[k] <= nx_best;
                st_win_reg[k]  <= nx_win;
                st_bins_reg[k] <= pv_bins;
                st_ok_reg[k]   <= pv_ok;
                st_meta_reg[k] <= pv_meta;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            m_valid_reg <= st_valid_reg[NCELL-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_row_reg    <= st_meta_reg[NCELL-1].row;
            m_col_reg    <= st_meta_reg[NCELL-1].col;
            m_run_reg    <= st_meta_reg[NCELL-1].run_last;
            m_frame_reg  <= st_meta_reg[NCELL-1].frame_last;
            m_onehot_reg <= st_ok_reg[NCELL-1][CENTER]
                            ? (NUM_BINS'(1) << st_win_reg[NCELL-1]) : '0;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_pixel_row  = m_row_reg;
    assign m_pixel_col  = m_col_reg;
    assign m_bin_onehot = m_onehot_reg;
    assign m_run_last   = m_run_reg;
    assign m_frame_last = m_frame_reg;

endmodule

>>> hdl/orientation_window_vote_quantizer_unit.sv
`timescale 1ns / 1ps
// Top level of the gradient orientation quantizer with a square-window bin vote.
// Throughput: one pixel per cycle; results leave at one per cycle while m_ready is high;
// bursts at row and frame ends queue up in a four-entry job queue and pause s_ready
// while it is full. A result is released by the pixel HALF_WINDOW rows and columns
// later, then passes the job queue and one vote stage per window cell to the output.
// Reset: synchronous active-low aresetn clears position, window, queue and pipeline valids.
module orientation_window_vote_quantizer_unit import owvq_pkg::*; #(
    parameter int MAX_WIDTH   = MAX_WIDTH_DEF,
    parameter int HALF_WINDOW = HALF_WINDOW_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [STR_W-1:0]     s_strength,
    input  logic [DIR_W-1:0]     s_direction,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [ROW_W-1:0]     m_pixel_row,
    output logic [OUT_COL_W-1:0] m_pixel_col,
    output logic [NUM_BINS-1:0]  m_bin_onehot,
    output logic                 m_run_last,
    output logic                 m_frame_last
);

    localparam int SPAN   = 2 * HALF_WINDOW + 1;
    localparam int NCELL  = SPAN * SPAN;
    localparam int OFF_W  = $clog2(HALF_WINDOW + 1);
    localparam int JOB_W  = NCELL * CODE_W + 2 * SPAN + 2 * OFF_W + $bits(job_meta_t);
    localparam int QCNT_W = $clog2(Q_DEPTH + 1);

    // Front to queue: one job per pixel that releases results.
    logic              job_push;
    logic [JOB_W-1:0]  job_data;
    logic [QCNT_W-1:0] q_count;

    // Queue to expander.
    logic              head_valid;
    logic [JOB_W-1:0]  head_data;
    logic              head_pop;

    // Expander to vote pipeline: one result request per cycle while the vote pipeline advances.
    logic                   res_valid;
    logic [NCELL*BIN_W-1:0] res_bins;
    logic [NCELL-1:0]       res_ok;
    res_meta_t              res_meta;
    logic                   vote_adv;

    // Classify each pixel, store its code and slide the window.
    owvq_front #(
        .MAX_WIDTH   (MAX_WIDTH),
        .HALF_WINDOW (HALF_WINDOW)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_strength  (s_strength),
        .s_direction (s_direction),
        .q_count     (q_count),
        .job_push    (job_push),
        .job_data    (job_data)
    );

    // Hold jobs so the front keeps taking pixels while a flush burst drains.
    owvq_job_fifo #(
        .WIDTH (JOB_W)
    ) u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (job_push),
        .push_data  (job_data),
        .pop        (head_pop),
        .head_valid (head_valid),
        .head_data  (head_data),
        .count      (q_count)
    );

    // Advance through the result centers of the head job.
    owvq_expand #(
        .HALF_WINDOW (HALF_WINDOW)
    ) u_expand (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (head_valid),
        .head_data  (head_data),
        .pop        (head_pop),
        .adv        (vote_adv),
        .res_valid  (res_valid),
        .res_bins   (res_bins),
        .res_ok     (res_ok),
        .res_meta   (res_meta)
    );

    // Count votes cell by cell; the whole pipeline holds while a result waits.
    owvq_vote #(
        .HALF_WINDOW (HALF_WINDOW)
    ) u_vote (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_valid     (res_valid),
        .in_bins      (res_bins),
        .in_ok        (res_ok),
        .in_meta      (res_meta),
        .adv          (vote_adv),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_pixel_row  (m_pixel_row),
        .m_pixel_col  (m_pixel_col),
        .m_bin_onehot (m_bin_onehot),
        .m_run_last   (m_run_last),
        .m_frame_last (m_frame_last)
    );

endmodule

>>> sim/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for the orientation window vote quantizer.
module testbench;
    import owvq_pkg::*;

    localparam int SPAN_ROWS    = 3;
    localparam int PRED_WIDTH   = 1024;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int SETTLE_CYCLES = 30;

    typedef struct packed {
        logic [ROW_W-1:0]     row;
        logic [OUT_COL_W-1:0] col;
        logic [NUM_BINS-1:0]  onehot;
        logic                 run_last;
        logic                 frame_last;
    } vote_result_t;

    typedef struct packed {
        logic [STR_W-1:0]    strength;
        logic [DIR_W-1:0]    direction;
        logic [NUM_BINS-1:0] onehot;
    } pixel_row_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = REG_FRAME_WIDTH;
    logic [CFG_W-1:0]     cfg_data = '0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic [STR_W-1:0]     s_strength = '0;
    logic [DIR_W-1:0]     s_direction = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic [ROW_W-1:0]     m_pixel_row;
    logic [OUT_COL_W-1:0] m_pixel_col;
    logic [NUM_BINS-1:0]  m_bin_onehot;
    logic                 m_run_last;
    logic                 m_frame_last;

    // Predictor copy of the block state and registers.
    logic [CODE_W-1:0] code_mem [SPAN_ROWS*PRED_WIDTH];
    int unsigned       pos_row, pos_col;
    logic [10:0]       reg_width;
    logic [15:0]       reg_height;
    logic [14:0]       reg_thresh;

    vote_result_t pending_votes[$];
    int           error_count = 0;
    int           pixel_count = 0;
    int           result_count = 0;
    int           setting_count = 0;
    int           cycle_count = 0;
    bit           quiet = 1'b0;
    int           stall_left = 0;

    // Directed rows run on a one-pixel frame, so every result is that pixel alone.
    pixel_row_t directed_rows [] = '{
        '{15'd52,    13'd0,    16'h0001},
        '{15'd51,    13'd100,  16'h0000},
        '{15'd0,     13'd0,    16'h0000},
        '{15'd25600, 13'd180,  16'h0001},
        '{15'd25600, 13'd181,  16'h0002},
        '{15'd1000,  13'd2700, 16'h4000},
        '{15'd25600, 13'd2880, 16'h8000},
        '{15'd25600, 13'd2881, 16'h0001},
        '{15'd25600, 13'd5759, 16'h8000},
        '{15'd25600, 13'd5761, 16'h0001},
        '{15'd25600, 13'd8191, 16'h0001}
    };

    orientation_window_vote_quantizer_unit u_top (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_strength   (s_strength),
        .s_direction  (s_direction),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_pixel_row  (m_pixel_row),
        .m_pixel_col  (m_pixel_col),
        .m_bin_onehot (m_bin_onehot),
        .m_run_last   (m_run_last),
        .m_frame_last (m_frame_last)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Hard stop in case the block hangs.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t timeout with %0d results outstanding", $time, pending_votes.size());
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Result side backpressure: random stall bursts, none in the quiet tail.
    always @(negedge aclk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_ready    <= 1'b0;
        end else if (!quiet && $urandom_range(0, 11) == 0) begin
            stall_left <= $urandom_range(1, 9) - 1;
            m_ready    <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Compare each accepted result against the oldest prediction.
    always @(posedge aclk) begin
        vote_result_t want;
        if (aresetn && m_valid && m_ready) begin
            result_count <= result_count + 1;
            if (pending_votes.size() == 0) begin
                $display("%0t unexpected result row %0d col %0d onehot %h", $time,
                         m_pixel_row, m_pixel_col, m_bin_onehot);
                error_count <= error_count + 1;
            end else begin
                want = pending_votes.pop_front();
                if (want.row !== m_pixel_row || want.col !== m_pixel_col ||
                    want.onehot !== m_bin_onehot || want.run_last !== m_run_last ||
                    want.frame_last !== m_frame_last) begin
                    $display("%0t mismatch expected row %0d col %0d onehot %h run %b frame %b",
                             $time, want.row, want.col, want.onehot, want.run_last,
                             want.frame_last);
                    $display("%0t          actual   row %0d col %0d onehot %h run %b frame %b",
                             $time, m_pixel_row, m_pixel_col, m_bin_onehot, m_run_last,
                             m_frame_last);
                    error_count <= error_count + 1;
                end
            end
        end
    end

    function automatic int unsigned active_width();
        if (reg_width < 11'd1) return 1;
        if (reg_width > PRED_WIDTH) return PRED_WIDTH;
        return reg_width;
    endfunction

    function automatic int unsigned active_height();
        return (reg_height == 16'd0) ? 1 : reg_height;
    endfunction

    // Fold to the half turn, then pick the first bin whose upper edge covers the angle.
    function automatic logic [BIN_W-1:0] direction_bin(input logic [DIR_W-1:0] dir);
        int unsigned a, b;
        a = dir;
        if (a > 2880) a = a - 2880;
        if (a == 0) return '0;
        b = (a - 1) / 180;
        return (b < NUM_BINS) ? b[BIN_W-1:0] : '0;
    endfunction

    function automatic logic [CODE_W-1:0] stored_code(input int unsigned r, input int unsigned c);
        return code_mem[(r % SPAN_ROWS) * PRED_WIDTH + (c % PRED_WIDTH)];
    endfunction

    function automatic logic [NUM_BINS-1:0] window_vote(input int unsigned r, input int unsigned c,
                                                        input int unsigned w, input int unsigned h);
        int unsigned  counts [NUM_BINS];
        int unsigned  best, win;
        int           rr, cc;
        logic [CODE_W-1:0] code;
        code = stored_code(r, c);
        if (!code[4]) return '0;
        foreach (counts[i]) counts[i] = 0;
        best = 0;
        win  = 0;
        for (rr = int'(r) - 1; rr <= int'(r) + 1; rr++) begin
            if (rr < 0 || rr >= int'(h)) continue;
            for (cc = int'(c) - 1; cc <= int'(c) + 1; cc++) begin
                if (cc < 0 || cc >= int'(w)) continue;
                code = stored_code(rr, cc);
                if (!code[4]) continue;
                counts[code[3:0]]++;
                // strictly greater: the first bin to reach the top count keeps it
                if (counts[code[3:0]] > best) begin
                    best = counts[code[3:0]];
                    win  = code[3:0];
                end
            end
        end
        return 16'(1) << win;
    endfunction

    // Advance the predictor by one accepted pixel and queue the results it releases.
    task automatic predict_pixel(input logic [STR_W-1:0] str, input logic [DIR_W-1:0] dir);
        int unsigned  w, h, r, c, rlo, rhi, clo, chi, rr, cc;
        bit           rows_ok, cols_ok;
        vote_result_t res;
        w = active_width();
        h = active_height();
        if (pos_col >= w) begin
            pos_col = 0;
            pos_row++;
        end
        if (pos_row >= h) pos_row = 0;
        r = pos_row;
        c = pos_col;
        code_mem[(r % SPAN_ROWS) * PRED_WIDTH + c] = {(str > reg_thresh), direction_bin(dir)};
        rows_ok = 1'b1;
        cols_ok = 1'b1;
        if (r == h - 1) begin
            rlo = (r >= 1) ? r - 1 : 0;
            rhi = r;
        end else if (r >= 1) begin
            rlo = r - 1;
            rhi = r - 1;
        end else begin
            rlo = 0;
            rhi = 0;
            rows_ok = 1'b0;
        end
        if (c == w - 1) begin
            clo = (c >= 1) ? c - 1 : 0;
            chi = c;
        end else if (c >= 1) begin
            clo = c - 1;
            chi = c - 1;
        end else begin
            clo = 0;
            chi = 0;
            cols_ok = 1'b0;
        end
        if (rows_ok && cols_ok) begin
            for (rr = rlo; rr <= rhi; rr++) begin
                for (cc = clo; cc <= chi; cc++) begin
                    res.row        = rr[ROW_W-1:0];
                    res.col        = cc[OUT_COL_W-1:0];
                    res.onehot     = window_vote(rr, cc, w, h);
                    res.run_last   = (rr == rhi && cc == chi);
                    res.frame_last = (rr == h - 1 && cc == w - 1);
                    pending_votes = {pending_votes, res};
                end
            end
        end
        pos_col++;
        if (pos_col >= w) begin
            pos_col = 0;
            pos_row++;
            if (pos_row >= h) pos_row = 0;
        end
    endtask

    // Offer one request; called and returns at a falling edge.
    task automatic send_pixel(input logic [STR_W-1:0] str, input logic [DIR_W-1:0] dir);
        if (!quiet && $urandom_range(0, 5) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge aclk);
        end
        s_valid     <= 1'b1;
        s_strength  <= str;
        s_direction <= dir;
        do @(posedge aclk); while (!s_ready);
        predict_pixel(str, dir);
        pixel_count++;
        @(negedge aclk);
    endtask

    // Strengths cluster around the threshold; directions cluster so votes collide.
    task automatic send_random_pixel();
        int unsigned str, dir;
        case ($urandom_range(0, 3))
            0: str = $urandom_range(0, 60);
            1: str = reg_thresh + $urandom_range(0, 4);
            default: str = $urandom_range(0, 25600);
        endcase
        if (str > 2) str = (str > reg_thresh + 2 && str < reg_thresh + 5) ? str - 2 : str;
        if (str > 25600) str = 25600;
        case ($urandom_range(0, 3))
            0: dir = $urandom_range(0, 3) * 720 + $urandom_range(0, 40);
            1: dir = $urandom_range(0, 31) * 180 + $urandom_range(0, 1);
            default: dir = $urandom_range(0, 5759);
        endcase
        send_pixel(str[STR_W-1:0], dir[DIR_W-1:0]);
    endtask

    // Feed pixels until the predictor sits at the start of a frame.
    task automatic finish_frame();
        do send_random_pixel(); while (!(pos_row == 0 && pos_col == 0));
    endtask

    // Hold until every predicted result is back, then let the pipeline settle.
    task automatic drain_results();
        s_valid <= 1'b0;
        while (pending_votes.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    // Write all three registers on consecutive cycles; only while idle.
    task automatic set_frame(input logic [15:0] w, input logic [15:0] h, input logic [15:0] th);
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_FRAME_WIDTH;
        cfg_data  <= w;
        @(negedge aclk);
        cfg_index <= REG_FRAME_HEIGHT;
        cfg_data  <= h;
        @(negedge aclk);
        cfg_index <= REG_STRENGTH_THRESHOLD;
        cfg_data  <= th;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        reg_width  = w[10:0];
        reg_height = h;
        reg_thresh = th[14:0];
        setting_count++;
    endtask

    initial begin
        pixel_row_t row_item;
        foreach (code_mem[i]) code_mem[i] = '0;
        pos_row    = 0;
        pos_col    = 0;
        reg_width  = WIDTH_RST;
        reg_height = HEIGHT_RST;
        reg_thresh = THRESHOLD_RST;

        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Width and height zero both act as one: each pixel is its own frame.
        set_frame(16'd0, 16'd0, 16'd51);
        foreach (directed_rows[i]) begin
            row_item = directed_rows[i];
            send_pixel(row_item.strength, row_item.direction);
            pending_votes[$].onehot = row_item.onehot;
        end
        drain_results();

        // Zero threshold: everything above zero counts; a short frame flushes its last row.
        set_frame(16'd8, 16'd3, 16'd0);
        finish_frame();
        drain_results();

        // Wider frame, then shrink the width mid-row so the next pixel wraps to a new row.
        set_frame(16'd16, 16'd8, 16'd51);
        repeat (12) send_random_pixel();
        drain_results();
        set_frame(16'd8, 16'd2, 16'd51);
        finish_frame();
        drain_results();

        // Width above the maximum clamps; height zero gives one row, then narrow it.
        set_frame(16'd2047, 16'd0, 16'd100);
        repeat (6) send_random_pixel();
        drain_results();
        set_frame(16'd8, 16'd0, 16'd100);
        finish_frame();
        drain_results();

        // Tallest frame and top threshold, then cut the height back to end the frame.
        set_frame(16'd8, 16'd65535, 16'd25600);
        repeat (12) send_random_pixel();
        drain_results();
        set_frame(16'd8, 16'd2, 16'd25600);
        finish_frame();
        drain_results();

        // Random frames; the last one runs without idling.
        for (int f = 0; f < 2; f++) begin
            set_frame(16'($urandom_range(8, 12)), 16'($urandom_range(1, 2)),
                      16'($urandom_range(0, 25600)));
            if (f == 1) quiet = 1'b1;
            finish_frame();
            drain_results();
        end

        $display("Covered %0d pixels and %0d results over %0d register settings",
                 pixel_count, result_count, setting_count);
        $display("Included clamped sizes, one-pixel frames, mid-frame wraps and bin folding");
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
